[rtl/core/urhs_pkg.sv]
// ----------------------------------------------------------------------------
// urhs_pkg
// Shared constants, codes, handshake structs and ring index helper for the
// bounded undo/redo history stack.
// ----------------------------------------------------------------------------
package urhs_pkg;

    // history size and stored payload width
    localparam int HISTORY_DEPTH = 32;
    localparam int STROKE_BITS   = 32;

    // derived widths
    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int ENTRY_W = STROKE_BITS + 1;

    // fixed port widths
    localparam int OPCODE_W  = 2;
    localparam int EFFECT_W  = 2;
    localparam int STROKE_W  = 32;
    localparam int DEPTH_W   = 6;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_UNDO   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REDO   = 2'd2;

    // reported effects
    localparam logic [EFFECT_W-1:0] EFF_NONE   = 2'd0;
    localparam logic [EFFECT_W-1:0] EFF_REMOVE = 2'd1;
    localparam logic [EFFECT_W-1:0] EFF_ADD    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_fast;    // finish an item that needs no stack read
        logic start_read;   // accept an item and read the top entry
        logic finish_read;  // entry is back, write it over and report
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic needs_read;   // item at the input pops a non-empty stack
    } t_sts;

    // ring position base + off, with off at most HISTORY_DEPTH
    function automatic logic [IDX_W-1:0] ring_slot(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(HISTORY_DEPTH)) begin
            sum = sum - (CNT_W+1)'(HISTORY_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[rtl/core/urhs_ram.sv]
// ----------------------------------------------------------------------------
// urhs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module urhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/urhs_ctrl.sv]
// ----------------------------------------------------------------------------
// urhs_ctrl
// Controller: input and output handshakes, sequencing of an item through
// the stack read and the write-back.
// ----------------------------------------------------------------------------
module urhs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  urhs_pkg::t_sts i_sts,
    output urhs_pkg::t_cmd o_cmd
);
    import urhs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   can_load;
    t_cmd   cmd;

    // output register is free after this edge
    assign can_load = !r_valid || !i_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && can_load) begin
                    if (i_sts.needs_read) begin
                        cmd.start_read = 1'b1;
                        n_state        = S_EXEC;
                    end else begin
                        cmd.load_fast = 1'b1;
                    end
                end
            end
            S_EXEC: begin
                if (can_load) begin
                    cmd.finish_read = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        if (cmd.load_fast || cmd.finish_read) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = !((r_state == S_IDLE) && can_load);
    assign o_valid = r_valid;
    assign o_cmd   = cmd;

endmodule

[rtl/core/urhs_dpath.sv]
// ----------------------------------------------------------------------------
// urhs_dpath
// Datapath: undo ring and redo stack memories, depth counters, ring base
// and the result register.
// ----------------------------------------------------------------------------
module urhs_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  urhs_pkg::t_cmd                    i_cmd,
    output urhs_pkg::t_sts                    o_sts,
    input  logic [urhs_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic                              i_action_kind,
    input  logic [urhs_pkg::STROKE_W-1:0]     i_stroke_data,
    output logic [urhs_pkg::EFFECT_W-1:0]     o_effect,
    output logic [urhs_pkg::STROKE_W-1:0]     o_effect_stroke,
    output logic [urhs_pkg::DEPTH_W-1:0]      o_undo_depth,
    output logic [urhs_pkg::DEPTH_W-1:0]      o_redo_depth
);
    import urhs_pkg::*;

    logic [CNT_W-1:0]    r_undo_count, n_undo_count;
    logic [CNT_W-1:0]    r_redo_count, n_redo_count;
    logic [IDX_W-1:0]    r_undo_base, n_undo_base;
    logic                r_is_redo;
    logic [EFFECT_W-1:0] r_effect, n_effect;
    logic [STROKE_W-1:0] r_stroke, n_stroke;

    logic                undo_full, redo_full;
    logic                is_record;
    logic [IDX_W-1:0]    undo_top_slot, undo_push_slot;
    logic                undo_we, undo_re, redo_we, redo_re;
    logic [ENTRY_W-1:0]  undo_wdata, undo_rdata, redo_rdata;
    logic [ENTRY_W-1:0]  popped;
    logic                popped_kind;

    assign undo_full = (r_undo_count == CNT_W'(HISTORY_DEPTH));
    assign redo_full = (r_redo_count == CNT_W'(HISTORY_DEPTH));
    assign is_record = (i_opcode == OP_RECORD);

    // an undo or redo on a non-empty stack needs a memory read
    assign o_sts.needs_read = ((i_opcode == OP_UNDO) && (r_undo_count != '0)) ||
                              ((i_opcode == OP_REDO) && (r_redo_count != '0));

    // ring addresses; when full the push slot wraps onto the oldest entry
    assign undo_top_slot  = ring_slot(r_undo_base, r_undo_count - 1'b1);
    assign undo_push_slot = ring_slot(r_undo_base, r_undo_count);

    // memory port control
    assign undo_re    = i_cmd.start_read && (i_opcode == OP_UNDO);
    assign redo_re    = i_cmd.start_read && (i_opcode == OP_REDO);
    assign undo_we    = (i_cmd.load_fast && is_record) ||
                        (i_cmd.finish_read && r_is_redo && !undo_full);
    assign redo_we    = i_cmd.finish_read && !r_is_redo && !redo_full;
    assign undo_wdata = i_cmd.load_fast ? {i_action_kind, STROKE_BITS'(i_stroke_data)}
                                        : redo_rdata;

    urhs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_undo_ram (
        .i_clk   (i_clk),
        .i_we    (undo_we),
        .i_waddr (undo_push_slot),
        .i_wdata (undo_wdata),
        .i_re    (undo_re),
        .i_raddr (undo_top_slot),
        .o_rdata (undo_rdata)
    );

    urhs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_redo_ram (
        .i_clk   (i_clk),
        .i_we    (redo_we),
        .i_waddr (r_redo_count[IDX_W-1:0]),
        .i_wdata (undo_rdata),
        .i_re    (redo_re),
        .i_raddr (IDX_W'(r_redo_count - 1'b1)),
        .o_rdata (redo_rdata)
    );

    // popped entry of the item in flight
    assign popped      = r_is_redo ? redo_rdata : undo_rdata;
    assign popped_kind = popped[ENTRY_W-1];

    // counters, ring base and result
    always_comb begin
        n_undo_count = r_undo_count;
        n_redo_count = r_redo_count;
        n_undo_base  = r_undo_base;
        n_effect     = r_effect;
        n_stroke     = r_stroke;
        if (i_cmd.load_fast) begin
            n_effect = EFF_NONE;
            n_stroke = '0;
            if (is_record) begin
                n_redo_count = '0;
                if (undo_full) begin
                    n_undo_base = ring_slot(r_undo_base, CNT_W'(1));
                end else begin
                    n_undo_count = r_undo_count + 1'b1;
                end
            end
        end else if (i_cmd.finish_read) begin
            n_stroke = STROKE_W'(popped[STROKE_BITS-1:0]);
            if (r_is_redo) begin
                n_effect     = popped_kind ? EFF_ADD : EFF_REMOVE;
                n_redo_count = r_redo_count - 1'b1;
                if (!undo_full) begin
                    n_undo_count = r_undo_count + 1'b1;
                end
            end else begin
                n_effect     = popped_kind ? EFF_REMOVE : EFF_ADD;
                n_undo_count = r_undo_count - 1'b1;
                if (!redo_full) begin
                    n_redo_count = r_redo_count + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undo_count <= '0;
            r_redo_count <= '0;
            r_undo_base  <= '0;
        end else begin
            r_undo_count <= n_undo_count;
            r_redo_count <= n_redo_count;
            r_undo_base  <= n_undo_base;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_read) begin
            r_is_redo <= (i_opcode == OP_REDO);
        end
        r_effect <= n_effect;
        r_stroke <= n_stroke;
    end

    assign o_effect        = r_effect;
    assign o_effect_stroke = r_stroke;
    assign o_undo_depth    = DEPTH_W'(r_undo_count);
    assign o_redo_depth    = DEPTH_W'(r_redo_count);

endmodule

[rtl/core/undo_redo_history_stack.sv]
// ----------------------------------------------------------------------------
// undo_redo_history_stack
// Bounded undo/redo history of stroke edits; reports the canvas effect of
// each record, undo or redo command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one command (opcode, action kind,
//   stroke). Output channel o_valid / i_stall carries one result per command:
//   effect, effect stroke and both stack depths after the command.
//   A record, an unused opcode, or an undo/redo on an empty stack completes
//   at the transfer edge: the result shows in the next cycle, and a new
//   command can follow at once unless the receiver stalls. An undo or redo
//   that pops an entry first does the registered read of the stack memory,
//   then writes the entry onto the other stack and loads the result register.
//   The result register lets a new command in while the old result is being
//   taken; when the receiver stalls, the result holds and further input is
//   stalled until the result can be replaced.
//   Synchronous active-low reset empties both stacks and the output; no
//   clearing pass is needed since only entries below the depths are read.
// ----------------------------------------------------------------------------
module undo_redo_history_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [urhs_pkg::OPCODE_W-1:0] i_opcode,
    input  logic                          i_action_kind,
    input  logic [urhs_pkg::STROKE_W-1:0] i_stroke_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [urhs_pkg::EFFECT_W-1:0] o_effect,
    output logic [urhs_pkg::STROKE_W-1:0] o_effect_stroke,
    output logic [urhs_pkg::DEPTH_W-1:0]  o_undo_depth,
    output logic [urhs_pkg::DEPTH_W-1:0]  o_redo_depth
);
    import urhs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing and handshakes
    urhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // stacks and result
    urhs_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_action_kind   (i_action_kind),
        .i_stroke_data   (i_stroke_data),
        .o_effect        (o_effect),
        .o_effect_stroke (o_effect_stroke),
        .o_undo_depth    (o_undo_depth),
        .o_redo_depth    (o_redo_depth)
    );

endmodule

[rtl/core/urhs_chk.sv]
// ----------------------------------------------------------------------------
// urhs_chk
// Port-level checker for the undo/redo history stack, bound to the top level.
// ----------------------------------------------------------------------------
module urhs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [urhs_pkg::OPCODE_W-1:0] i_opcode,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [urhs_pkg::EFFECT_W-1:0] o_effect,
    input logic [urhs_pkg::STROKE_W-1:0] o_effect_stroke,
    input logic [urhs_pkg::DEPTH_W-1:0]  o_undo_depth,
    input logic [urhs_pkg::DEPTH_W-1:0]  o_redo_depth
);
    import urhs_pkg::*;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_effect) && $stable(o_effect_stroke))
        else $error("stalled result changed");

    // a record empties the redo stack and reports no effect
    a_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_opcode == OP_RECORD)
        |=> (o_redo_depth == '0) && (o_undo_depth != '0) && (o_effect == EFF_NONE))
        else $error("record result wrong");

    // depths stay within the history size
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_undo_depth <= DEPTH_W'(HISTORY_DEPTH)) &&
        (o_redo_depth <= DEPTH_W'(HISTORY_DEPTH)))
        else $error("stack depth out of range");

endmodule

bind undo_redo_history_stack urhs_chk u_chk (.*);
